### rtl/core/iwc_pkg.sv
`default_nettype none
package iwc_pkg;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_FLIP   = 2'd2,
		OP_ENERGY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_SIDE      = 2'd0,
		CFG_THRESHOLD = 2'd1,
		CFG_SEED      = 2'd2,
		CFG_NONE      = 2'd3
	} cfg_idx_t;

	localparam logic [6:0]  SIDE_RESET      = 7'd64;
	localparam logic [31:0] THRESHOLD_RESET = 32'h8000_0000;
	localparam logic [31:0] SEED_RESET      = 32'd1;

	// Width of the side arithmetic: holds any side up to 256 plus one.
	localparam int SIDE_W = 9;

endpackage
`default_nettype wire

### rtl/core/iwc_cfg_if.sv
`default_nettype none
interface iwc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  addr;
	logic [31:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/iwc_item_if.sv
`default_nettype none
interface iwc_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [5:0] row;
	logic [5:0] col;
	logic       spin_in;

	modport source (output valid, output opcode, output row, output col, output spin_in,
		input ready);
	modport sink (input valid, input opcode, input row, input col, input spin_in,
		output ready);
endinterface
`default_nettype wire

### rtl/core/iwc_result_if.sv
`default_nettype none
interface iwc_result_if;
	logic               valid;
	logic               ready;
	logic               spin_out;
	logic signed [13:0] energy;
	logic [12:0]        flipped_count;

	modport source (output valid, output spin_out, output energy, output flipped_count,
		input ready);
	modport sink (input valid, input spin_out, input energy, input flipped_count,
		output ready);
endinterface
`default_nettype wire

### rtl/core/ising_wolff_cluster_update.sv
`default_nettype none
// Channel  Role    Word
// cfg      sink    addr (register index), data
// item     sink    opcode, row, col, spin_in
// result   source  spin_out, energy, flipped_count
//
// A write goes from idle straight to done; a read passes through the read wait state. A flip
// reads each neighbour in the neighbour state and checks it in the check state, and takes each
// stack pop in the pop state. Energy takes one site per cycle through the two read ports.
// After reset a clearing pass over all MAX_SIDE-rounded-up-to-a-power-of-two squared spin
// addresses (4096 by default) zeroes the spins before the first word is taken. A stalled
// result holds in the output register.
module ising_wolff_cluster_update
	import iwc_pkg::*;
#(
	parameter int MAX_SIDE = 64
) (
	input wire logic     clk,
	input wire logic     arst_n,
	iwc_cfg_if.sink      cfg,
	iwc_item_if.sink     item,
	iwc_result_if.source result
);

	localparam int CW = (MAX_SIDE < 2) ? 1 : $clog2(MAX_SIDE);
	localparam int AW = 2 * CW;
	localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

	typedef enum logic [9:0] {
		S_CLR    = 10'b00_0000_0001,
		S_IDLE   = 10'b00_0000_0010,
		S_RDWAIT = 10'b00_0000_0100,
		S_SEED   = 10'b00_0000_1000,
		S_NB     = 10'b00_0001_0000,
		S_CHK    = 10'b00_0010_0000,
		S_POP    = 10'b00_0100_0000,
		S_ESWEEP = 10'b00_1000_0000,
		S_EDRAIN = 10'b01_0000_0000,
		S_DONE   = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	logic [6:0]         side_q;
	logic [31:0]        thr_q;
	logic [AW-1:0]      clr_q;
	logic               in_range_q;
	logic               cs_q;
	logic [AW-1:0]      top_site_q;
	logic [1:0]         top_d_q;
	logic [AW:0]        sp_q;
	logic [AW-1:0]      nb_q;
	logic [AW:0]        count_q;
	logic               res_spin_q;
	logic signed [13:0] res_energy_q;
	logic [CW-1:0]      er_q;
	logic [CW-1:0]      ec_q;
	logic               prev_a_q;
	logic               ev_s1;
	logic               evert_s1;
	logic               ehoriz_s1;

	logic               out_valid_q;
	logic               out_spin_q;
	logic signed [13:0] out_energy_q;
	logic [12:0]        out_count_q;

	logic [SIDE_W-1:0] side9;
	logic [SIDE_W-1:0] leff;
	logic [SIDE_W-1:0] rowx;
	logic [SIDE_W-1:0] colx;
	logic              in_range;
	logic [AW-1:0]     item_addr;
	logic              item_acc;

	logic [CW-1:0] tr;
	logic [CW-1:0] tc;
	logic [CW-1:0] nr;
	logic [CW-1:0] nc;
	logic          nb_ok;
	logic [AW-1:0] nb_addr;
	logic          add_ok;
	logic          last_site;
	logic          row_end;
	logic [AW:0]   sp_m1;
	logic [AW:0]   sp_m2;
	logic signed [2:0] bond_sum;

	logic          spin_we;
	logic [AW-1:0] spin_wa;
	logic          spin_wd;
	logic [AW-1:0] rd_a_addr;
	logic [AW-1:0] rd_b_addr;
	logic          rd_a_data;
	logic          rd_b_data;
	logic          stk_we;
	logic [AW+1:0] stk_wd;
	logic [AW-1:0] stk_ra;
	logic [AW+1:0] stk_rd;
	logic          rng_step;
	logic          rng_load;
	logic [31:0]   draw;

	assign side9     = SIDE_W'(side_q);
	assign leff      = (side9 < SIDE_W'(2)) ? SIDE_W'(2) : ((side9 > SIDE_MAX) ? SIDE_MAX : side9);
	assign rowx      = SIDE_W'(item.row);
	assign colx      = SIDE_W'(item.col);
	assign in_range  = (rowx < leff) && (colx < leff);
	assign item_addr = {rowx[CW-1:0], colx[CW-1:0]};
	assign item.ready = (state_q == S_IDLE);
	assign item_acc  = item.valid && item.ready;
	assign cfg.ready = 1'b1;
	assign rng_load  = cfg.valid && (cfg.addr == CFG_SEED);

	assign tr = top_site_q[AW-1:CW];
	assign tc = top_site_q[CW-1:0];

	always_comb begin
		nr    = tr;
		nc    = tc;
		nb_ok = 1'b0;
		unique case (top_d_q)
			2'd0: begin
				nb_ok = (tr != '0);
				nr    = tr - CW'(1);
			end
			2'd1: begin
				nb_ok = (SIDE_W'(tr) + SIDE_W'(1)) < leff;
				nr    = tr + CW'(1);
			end
			2'd2: begin
				nb_ok = (tc != '0);
				nc    = tc - CW'(1);
			end
			2'd3: begin
				nb_ok = (SIDE_W'(tc) + SIDE_W'(1)) < leff;
				nc    = tc + CW'(1);
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	// A site already in the cluster has been flipped, so a like spin marks it unvisited.
	assign nb_addr   = {nr, nc};
	assign add_ok    = (rd_a_data == cs_q) && (draw < thr_q);
	assign sp_m1     = sp_q - (AW+1)'(1);
	assign sp_m2     = sp_q - (AW+1)'(2);
	assign row_end   = (SIDE_W'(ec_q) == (leff - SIDE_W'(1)));
	assign last_site = row_end && (SIDE_W'(er_q) == (leff - SIDE_W'(1)));

	always_comb begin
		bond_sum = 3'sd0;
		if (evert_s1) begin
			bond_sum = bond_sum + ((rd_a_data == rd_b_data) ? -3'sd1 : 3'sd1);
		end
		if (ehoriz_s1) begin
			bond_sum = bond_sum + ((rd_a_data == prev_a_q) ? -3'sd1 : 3'sd1);
		end
	end

	always_comb begin
		spin_we   = 1'b0;
		spin_wa   = item_addr;
		spin_wd   = item.spin_in;
		rd_a_addr = item_addr;
		rd_b_addr = item_addr;
		stk_we    = 1'b0;
		stk_wd    = {top_site_q, top_d_q + 2'd1};
		stk_ra    = sp_m2[AW-1:0];
		rng_step  = 1'b0;
		unique case (state_q)
			S_CLR: begin
				spin_we = 1'b1;
				spin_wa = clr_q;
				spin_wd = 1'b0;
			end
			S_IDLE: begin
				spin_we = item_acc && (item.opcode == OP_WRITE) && in_range;
			end
			S_SEED: begin
				spin_we = 1'b1;
				spin_wa = top_site_q;
				spin_wd = ~rd_a_data;
			end
			S_NB: begin
				rd_a_addr = nb_addr;
			end
			S_CHK: begin
				rng_step = (rd_a_data == cs_q);
				if (add_ok) begin
					spin_we = 1'b1;
					spin_wa = nb_q;
					spin_wd = ~cs_q;
					stk_we  = (top_d_q != 2'd3);
				end
			end
			S_ESWEEP: begin
				rd_a_addr = {er_q, ec_q};
				rd_b_addr = {er_q + CW'(1), ec_q};
			end
			S_RDWAIT, S_POP, S_EDRAIN, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	iwc_spin_mem #(.AW(AW)) u_spin (
		.clk         (clk),
		.we          (spin_we),
		.wr_addr     (spin_wa),
		.wr_data     (spin_wd),
		.rd_a_addr   (rd_a_addr),
		.rd_b_addr   (rd_b_addr),
		.rd_a_data_q (rd_a_data),
		.rd_b_data_q (rd_b_data)
	);

	iwc_stack_mem #(.AW(AW)) u_stack (
		.clk       (clk),
		.we        (stk_we),
		.wr_addr   (sp_m1[AW-1:0]),
		.wr_data   (stk_wd),
		.rd_addr   (stk_ra),
		.rd_data_q (stk_rd)
	);

	iwc_rng u_rng (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (rng_load),
		.seed   (cfg.data),
		.step   (rng_step),
		.draw   (draw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RESET;
			thr_q  <= THRESHOLD_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.addr))
				CFG_SIDE:      side_q <= cfg.data[6:0];
				CFG_THRESHOLD: thr_q  <= cfg.data;
				CFG_SEED, CFG_NONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ev_s1     <= (state_q == S_ESWEEP);
		evert_s1  <= (SIDE_W'(er_q) + SIDE_W'(1)) < leff;
		ehoriz_s1 <= (ec_q != '0);
		if (ev_s1) begin
			prev_a_q <= rd_a_data;
		end
		unique case (state_q)
			S_IDLE: begin
				res_spin_q   <= 1'b0;
				res_energy_q <= '0;
				count_q      <= '0;
				in_range_q   <= in_range;
				top_site_q   <= item_addr;
				top_d_q      <= 2'd0;
				sp_q         <= (AW+1)'(1);
				er_q         <= '0;
				ec_q         <= '0;
			end
			S_RDWAIT: begin
				res_spin_q <= in_range_q & rd_a_data;
			end
			S_SEED: begin
				cs_q    <= rd_a_data;
				count_q <= (AW+1)'(1);
			end
			S_NB: begin
				nb_q <= nb_addr;
				if (!nb_ok) begin
					if (top_d_q != 2'd3) begin
						top_d_q <= top_d_q + 2'd1;
					end else if (sp_q != (AW+1)'(1)) begin
						sp_q <= sp_m1;
					end
				end
			end
			S_CHK: begin
				if (add_ok) begin
					count_q    <= count_q + (AW+1)'(1);
					top_site_q <= nb_q;
					top_d_q    <= 2'd0;
					if (top_d_q != 2'd3) begin
						sp_q <= sp_q + (AW+1)'(1);
					end
				end else if (top_d_q != 2'd3) begin
					top_d_q <= top_d_q + 2'd1;
				end else if (sp_q != (AW+1)'(1)) begin
					sp_q <= sp_m1;
				end
			end
			S_POP: begin
				top_site_q <= stk_rd[AW+1:2];
				top_d_q    <= stk_rd[1:0];
			end
			S_ESWEEP: begin
				if (row_end) begin
					ec_q <= '0;
					er_q <= er_q + CW'(1);
				end else begin
					ec_q <= ec_q + CW'(1);
				end
			end
			S_CLR, S_EDRAIN, S_DONE: begin
			end
			default: begin
			end
		endcase
		if (ev_s1) begin
			res_energy_q <= res_energy_q + 14'(bond_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_acc) begin
						unique case (op_t'(item.opcode))
							OP_WRITE:  state_q <= S_DONE;
							OP_READ:   state_q <= S_RDWAIT;
							OP_FLIP:   state_q <= in_range ? S_SEED : S_DONE;
							OP_ENERGY: state_q <= S_ESWEEP;
							default:   state_q <= S_DONE;
						endcase
					end
				end
				S_RDWAIT: state_q <= S_DONE;
				S_SEED:   state_q <= S_NB;
				S_NB: begin
					if (nb_ok) begin
						state_q <= S_CHK;
					end else if (top_d_q == 2'd3) begin
						state_q <= (sp_q == (AW+1)'(1)) ? S_DONE : S_POP;
					end
				end
				S_CHK: begin
					if (add_ok || (top_d_q != 2'd3)) begin
						state_q <= S_NB;
					end else begin
						state_q <= (sp_q == (AW+1)'(1)) ? S_DONE : S_POP;
					end
				end
				S_POP:    state_q <= S_NB;
				S_ESWEEP: state_q <= last_site ? S_EDRAIN : S_ESWEEP;
				S_EDRAIN: state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && (!out_valid_q || result.ready)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && (!out_valid_q || result.ready)) begin
			out_spin_q   <= res_spin_q;
			out_energy_q <= res_energy_q;
			out_count_q  <= 13'(count_q);
		end
	end

	assign result.valid         = out_valid_q;
	assign result.spin_out      = out_spin_q;
	assign result.energy        = out_energy_q;
	assign result.flipped_count = out_count_q;

endmodule
`default_nettype wire

### rtl/core/iwc_spin_mem.sv
`default_nettype none
module iwc_spin_mem #(
	parameter int AW = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic          wr_data,
	input  wire logic [AW-1:0] rd_a_addr,
	input  wire logic [AW-1:0] rd_b_addr,
	output logic               rd_a_data_q,
	output logic               rd_b_data_q
);

	logic mem_q [2**AW];

	// Two read ports so that the energy sweep sees a site and the one below it together.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_a_data_q <= mem_q[rd_a_addr];
		rd_b_data_q <= mem_q[rd_b_addr];
	end

endmodule
`default_nettype wire

### rtl/core/iwc_stack_mem.sv
`default_nettype none
module iwc_stack_mem #(
	parameter int AW = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [AW+1:0] wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [AW+1:0] rd_data_q
);

	logic [AW+1:0] mem_q [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

### rtl/core/iwc_rng.sv
`default_nettype none
module iwc_rng
	import iwc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire logic [31:0] seed,
	input  wire logic        step,
	output logic      [31:0] draw
);

	logic [31:0] state_q;
	logic [31:0] x1;
	logic [31:0] x2;

	always_comb begin
		x1   = state_q ^ (state_q << 13);
		x2   = x1 ^ (x1 >> 17);
		draw = x2 ^ (x2 << 5);
	end

	// A zero seed would lock the generator, so it loads as one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEED_RESET;
		end else if (load) begin
			state_q <= (seed == 32'd0) ? 32'd1 : seed;
		end else if (step) begin
			state_q <= draw;
		end
	end

endmodule
`default_nettype wire

### rtl/core/iwc_checker.sv
`default_nettype none
module iwc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_ready,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic        spin_out,
	input wire logic [13:0] energy,
	input wire logic [12:0] flipped_count
);

	// Each word is worked on alone, so the input side closes after a transfer.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input taken on two consecutive cycles");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(energy)
			&& $stable(flipped_count) && $stable(spin_out))
		else $error("stalled result changed");

	// Only one opcode produces each field, so two of them are never nonzero together.
	a_fields_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (energy == 14'd0) || (flipped_count == 13'd0))
		else $error("energy and flip count both set");

	a_spin_alone: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && spin_out |-> (energy == 14'd0) && (flipped_count == 13'd0))
		else $error("spin read with other fields set");

endmodule

bind ising_wolff_cluster_update iwc_checker u_iwc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.spin_out      (result.spin_out),
	.energy        (result.energy),
	.flipped_count (result.flipped_count)
);
`default_nettype wire

### sim/testbench.sv
module testbench
	import iwc_pkg::*;
();

	localparam int LATTICE = 64;
	localparam int SITES = LATTICE * LATTICE;
	localparam int WATCHDOG_LIMIT = 300000;

	typedef struct {
		op_t        opcode;
		logic [5:0] row;
		logic [5:0] col;
		logic       spin_in;
	} lattice_cmd_t;

	typedef struct {
		logic               spin_out;
		logic signed [13:0] energy;
		logic [12:0]        flipped_count;
	} lattice_reply_t;

	logic clk;
	logic arst_n;

	iwc_cfg_if    cfg ();
	iwc_item_if   item ();
	iwc_result_if result ();

	ising_wolff_cluster_update #(.MAX_SIDE(LATTICE)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.result (result)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Mirror of the lattice and its settings.
	bit          lattice_spin [SITES];
	bit          bond_mark [SITES];
	int unsigned walk_stack [SITES];
	logic [31:0] rng_state;
	logic [6:0]  cfg_side;
	logic [31:0] cfg_threshold;

	lattice_cmd_t   pending_cmds [$];
	lattice_reply_t expected_replies [$];
	lattice_cmd_t   driven_cmd;
	int             mismatches;
	int             idle_cycles;
	int             cmd_gap;
	int             reply_stall;
	bit             cmd_quiet;
	bit             reply_quiet;

	function automatic int unsigned used_side();
		if (cfg_side < 2)
			return 2;
		if (cfg_side > LATTICE)
			return LATTICE;
		return cfg_side;
	endfunction

	function automatic logic [31:0] next_random();
		logic [31:0] x;
		x = rng_state;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		rng_state = x;
		return x;
	endfunction

	function automatic int unsigned grow_and_flip(int unsigned r0, int unsigned c0,
		int unsigned l);
		int unsigned sp, count, seed, e, site, d, r, c, nr, nc, nb;
		bit ok;
		bit cs;
		seed = r0 * LATTICE + c0;
		cs = lattice_spin[seed];
		foreach (bond_mark[i])
			bond_mark[i] = 1'b0;
		bond_mark[seed] = 1'b1;
		lattice_spin[seed] = ~lattice_spin[seed];
		count = 1;
		walk_stack[0] = seed << 2;
		sp = 1;
		while (sp > 0) begin
			e = walk_stack[sp - 1];
			site = e >> 2;
			d = e & 3;
			r = site / LATTICE;
			c = site % LATTICE;
			nr = r;
			nc = c;
			if (d == 3)
				sp--;
			else
				walk_stack[sp - 1] = e + 1;
			case (d)
				0: begin ok = r > 0; nr = r - 1; end
				1: begin ok = r + 1 < l; nr = r + 1; end
				2: begin ok = c > 0; nc = c - 1; end
				default: begin ok = c + 1 < l; nc = c + 1; end
			endcase
			if (ok) begin
				nb = nr * LATTICE + nc;
				if (!bond_mark[nb] && lattice_spin[nb] == cs) begin
					if (next_random() < cfg_threshold && sp < SITES) begin
						bond_mark[nb] = 1'b1;
						lattice_spin[nb] = ~lattice_spin[nb];
						count++;
						walk_stack[sp] = nb << 2;
						sp++;
					end
				end
			end
		end
		return count;
	endfunction

	function automatic logic signed [13:0] bond_energy(int unsigned l);
		int sum;
		bit a;
		sum = 0;
		for (int unsigned r = 0; r < l; r++) begin
			for (int unsigned c = 0; c < l; c++) begin
				a = lattice_spin[r * LATTICE + c];
				if (r + 1 < l)
					sum += (a == lattice_spin[(r + 1) * LATTICE + c]) ? -1 : 1;
				if (c + 1 < l)
					sum += (a == lattice_spin[r * LATTICE + c + 1]) ? -1 : 1;
			end
		end
		return sum[13:0];
	endfunction

	function automatic lattice_reply_t apply_cmd(lattice_cmd_t cmd);
		lattice_reply_t rep;
		int unsigned l;
		bit in_lattice;
		int unsigned idx;
		l = used_side();
		in_lattice = cmd.row < l && cmd.col < l;
		idx = cmd.row * LATTICE + cmd.col;
		rep.spin_out = 1'b0;
		rep.energy = '0;
		rep.flipped_count = '0;
		case (cmd.opcode)
			OP_WRITE: if (in_lattice) lattice_spin[idx] = cmd.spin_in;
			OP_READ: if (in_lattice) rep.spin_out = lattice_spin[idx];
			OP_FLIP: if (in_lattice)
				rep.flipped_count = 13'(grow_and_flip(cmd.row, cmd.col, l));
			default: rep.energy = bond_energy(l);
		endcase
		return rep;
	endfunction

	function automatic int draw_wait(inout bit quiet);
		if ($urandom_range(0, 39) == 0)
			quiet = ~quiet;
		return quiet ? 0 : $urandom_range(0, 19);
	endfunction

	// Command driver: a word is held until the block takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item.valid <= 1'b0;
			item.opcode <= OP_WRITE;
			item.row <= '0;
			item.col <= '0;
			item.spin_in <= 1'b0;
			cmd_gap = 0;
		end else begin
			if (item.valid && item.ready) begin
				expected_replies.push_back(apply_cmd(driven_cmd));
				cmd_gap = draw_wait(cmd_quiet);
			end
			if (item.valid && !item.ready) begin
			end else if (cmd_gap > 0) begin
				cmd_gap--;
				item.valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				driven_cmd = pending_cmds.pop_front();
				item.valid <= 1'b1;
				item.opcode <= driven_cmd.opcode;
				item.row <= driven_cmd.row;
				item.col <= driven_cmd.col;
				item.spin_in <= driven_cmd.spin_in;
			end else begin
				item.valid <= 1'b0;
			end
		end
	end

	// Reply monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		lattice_reply_t want;
		if (!arst_n) begin
			result.ready <= 1'b0;
			reply_stall = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected reply: spin %0d energy %0d flipped %0d",
							result.spin_out, result.energy, result.flipped_count);
				end else begin
					want = expected_replies.pop_front();
					if (result.spin_out !== want.spin_out || result.energy !== want.energy ||
						result.flipped_count !== want.flipped_count) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"reply mismatch: want spin %0d energy %0d flipped %0d,",
								" got %0d %0d %0d"},
								want.spin_out, want.energy, want.flipped_count,
								result.spin_out, result.energy, result.flipped_count);
					end
				end
				reply_stall = draw_wait(reply_quiet);
			end
			if (reply_stall > 0) begin
				reply_stall--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item.valid && item.ready) || (result.valid && result.ready) ||
				(cfg.valid && cfg.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.addr <= idx;
		cfg.data <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			CFG_SIDE: cfg_side = value[6:0];
			CFG_THRESHOLD: cfg_threshold = value;
			CFG_SEED: rng_state = (value == 0) ? 32'd1 : value;
			default: ;
		endcase
	endtask

	task automatic push_cmd(op_t op, int r, int c, bit s);
		lattice_cmd_t cmd;
		cmd.opcode = op;
		cmd.row = 6'(r);
		cmd.col = 6'(c);
		cmd.spin_in = s;
		pending_cmds.push_back(cmd);
	endtask

	task automatic drain();
		while (pending_cmds.size() > 0 || item.valid || expected_replies.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_cmds(int count);
		int unsigned l;
		int k;
		op_t op;
		l = used_side();
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, 99);
			op = k < 40 ? OP_WRITE : k < 60 ? OP_READ : k < 85 ? OP_FLIP : OP_ENERGY;
			if ($urandom_range(0, 9) == 0)
				push_cmd(op, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
			else
				push_cmd(op, $urandom_range(0, l - 1), $urandom_range(0, l - 1),
					$urandom_range(0, 1));
		end
	endtask

	initial begin
		logic [6:0]  sides [12];
		logic [31:0] thr;
		sides = '{7'd3, 7'd0, 7'd5, 7'd64, 7'd8, 7'd1, 7'd127, 7'd12, 7'd2, 7'd65, 7'd6, 7'd4};
		mismatches = 0;
		idle_cycles = 0;
		cmd_quiet = 1'b0;
		reply_quiet = 1'b0;
		foreach (lattice_spin[i]) begin
			lattice_spin[i] = 1'b0;
			bond_mark[i] = 1'b0;
		end
		cfg_side = SIDE_RESET;
		cfg_threshold = THRESHOLD_RESET;
		rng_state = SEED_RESET;
		cfg.valid = 1'b0;
		cfg.addr = CFG_NONE;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset side: uniform lattice, corners, full flip at the top threshold.
		push_cmd(OP_READ, 0, 0, 0);
		push_cmd(OP_ENERGY, 0, 0, 0);
		push_cmd(OP_WRITE, 63, 63, 1);
		push_cmd(OP_READ, 63, 63, 0);
		push_cmd(OP_WRITE, 63, 63, 0);
		drain();
		write_reg(CFG_THRESHOLD, 32'hFFFF_FFFF);
		push_cmd(OP_FLIP, 0, 0, 0);
		push_cmd(OP_ENERGY, 0, 0, 0);
		push_cmd(OP_READ, 42, 21, 0);
		drain();
		// Tiny lattice: sites outside it are ignored and flips there draw nothing.
		write_reg(CFG_SIDE, 7'd0);
		write_reg(CFG_SEED, 32'd0);
		write_reg(CFG_THRESHOLD, 32'd0);
		push_cmd(OP_WRITE, 5, 5, 0);
		push_cmd(OP_READ, 63, 0, 0);
		push_cmd(OP_READ, 5, 5, 0);
		push_cmd(OP_FLIP, 2, 0, 0);
		push_cmd(OP_FLIP, 1, 1, 0);
		push_cmd(OP_WRITE, 0, 1, 0);
		push_cmd(OP_ENERGY, 0, 0, 0);
		drain();
		write_reg(CFG_THRESHOLD, 32'h8000_0000);
		push_cmd(OP_FLIP, 0, 0, 0);
		push_cmd(OP_FLIP, 0, 1, 0);
		push_cmd(OP_READ, 1, 1, 0);
		push_cmd(OP_ENERGY, 0, 0, 0);
		drain();

		for (int p = 0; p < 12; p++) begin
			case (p % 4)
				0: thr = $urandom;
				1: thr = 32'd0;
				2: thr = 32'hFFFF_FFFF;
				default: thr = 32'h8000_0000 + $urandom_range(0, 255);
			endcase
			write_reg(CFG_SIDE, sides[p]);
			write_reg(CFG_THRESHOLD, thr);
			write_reg(CFG_SEED, (p == 4) ? 32'hFFFF_FFFF : $urandom);
			random_cmds(73);
			drain();
		end

		repeat (100) @(posedge clk);
		mismatches += expected_replies.size();
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
